>>> rtl/hash_occurrence_counter_macros.svh
// Assertion macros shared by the hash occurrence counter RTL.
`ifndef HASH_OCCURRENCE_COUNTER_MACROS_SVH
`define HASH_OCCURRENCE_COUNTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HOC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hoc_pkg.sv
// Types, constants and codes shared by the hash occurrence counter modules.
`timescale 1ns / 1ps
package hoc_pkg;

    // The bucket count is a power of two so that the bucket is the low hash bits.
    localparam int BUCKET_BITS = 10;
    localparam int BUCKETS     = 1 << BUCKET_BITS;
    localparam int WAYS        = 4;

    localparam int KEY_W   = 24;
    localparam int COUNT_W = 16;
    localparam int HASH_W  = 32;
    localparam int DIGIT_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Division by ten as a multiplication by a reciprocal; exact for all 24-bit values.
    localparam logic [KEY_W-1:0] DIV10_MUL   = 24'hCCCCCD;
    localparam int               DIV10_SHIFT = 27;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [KEY_W-1:0]   key;
    } t_in_req;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               status;
    } t_out_rsp;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic                   done;
        logic [BUCKET_BITS-1:0] bucket;
    } t_hash_res;

    typedef struct packed {
        logic     we;
        t_row     row;
        t_out_rsp rsp;
    } t_update;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MODIFY,
        ST_RESP
    } t_state;

endpackage

>>> rtl/hoc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module hoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hoc_hash.sv
// Digit-walking key hash, one decimal digit per cycle.
`timescale 1ns / 1ps
module hoc_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hoc_pkg::KEY_W-1:0]  i_key,
    output hoc_pkg::t_hash_res         o_res
);
    import hoc_pkg::*;

    logic [KEY_W-1:0]   r_k;
    logic [DIGIT_W-1:0] r_d;
    logic               r_dv;
    logic [HASH_W-1:0]  r_h;
    logic               r_seed;
    logic               r_busy;
    logic               r_done;

    logic [2*KEY_W-1:0] w_prod;
    logic [KEY_W-1:0]   w_q;
    logic [KEY_W-1:0]   w_q10;
    logic [KEY_W-1:0]   w_rem;
    logic [DIGIT_W-1:0] w_d;
    logic [HASH_W-1:0]  w_h_next;
    logic               w_last;

    // Quotient and remainder of the remaining key by ten.
    assign w_prod = {{KEY_W{1'b0}}, r_k} * {{KEY_W{1'b0}}, DIV10_MUL};
    assign w_q    = KEY_W'(w_prod >> DIV10_SHIFT);
    assign w_q10  = (w_q << 3) + (w_q << 1);
    assign w_rem  = r_k - w_q10;
    assign w_d    = w_rem[DIGIT_W-1:0];

    // The digit extracted last cycle is folded into the hash this cycle.
    assign w_h_next = r_dv ? (r_h ^ ((r_h << 5) + (r_h >> 2)
                                     + {{(HASH_W-DIGIT_W){1'b0}}, r_d}))
                           : r_h;

    assign w_last = !r_seed && (r_k == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k    <= i_key;
            r_seed <= 1'b1;
            r_dv   <= 1'b0;
        end else if (r_busy) begin
            // The lowest digit seeds the hash and is then walked like every other digit.
            r_h    <= r_seed ? {{(HASH_W-DIGIT_W){1'b0}}, w_d} : w_h_next;
            r_seed <= 1'b0;
            r_dv   <= (r_k != '0);
            r_d    <= w_d;
            r_k    <= w_q;
        end
    end

    assign o_res.done   = r_done;
    assign o_res.bucket = r_h[BUCKET_BITS-1:0];

endmodule

>>> rtl/hoc_update.sv
// Set lookup and update: finds the key among the ways of one row and builds the new row.
`timescale 1ns / 1ps
module hoc_update (
    input  hoc_pkg::t_row              i_row,
    input  hoc_pkg::t_action           i_action,
    input  logic [hoc_pkg::KEY_W-1:0]  i_key,
    output hoc_pkg::t_update           o_upd
);
    import hoc_pkg::*;

    logic [WAYS-1:0]    w_hit;
    logic [WAYS-1:0]    w_free;
    logic               w_any_hit;
    logic               w_any_free;
    logic [COUNT_W-1:0] w_hit_count;

    // Lowest matching way and lowest empty way, each as a one-hot mask.
    always_comb begin
        w_any_hit   = 1'b0;
        w_any_free  = 1'b0;
        w_hit       = '0;
        w_free      = '0;
        w_hit_count = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!w_any_hit && i_row[w].valid && (i_row[w].key == i_key)) begin
                w_hit[w]    = 1'b1;
                w_any_hit   = 1'b1;
                w_hit_count = i_row[w].count;
            end
            if (!w_any_free && !i_row[w].valid) begin
                w_free[w]  = 1'b1;
                w_any_free = 1'b1;
            end
        end
    end

    always_comb begin
        o_upd.row        = i_row;
        o_upd.we         = 1'b0;
        o_upd.rsp.count  = '0;
        o_upd.rsp.status = 1'b0;
        case (i_action)
            ACT_QUERY: begin
                o_upd.rsp.count = w_hit_count;
            end
            ACT_INSERT: begin
                o_upd.we = w_any_hit || w_any_free;
                if (w_any_hit) begin
                    o_upd.rsp.count = (w_hit_count == COUNT_MAX) ? COUNT_MAX
                                                                 : w_hit_count + 1'b1;
                end else if (w_any_free) begin
                    o_upd.rsp.count = COUNT_W'(1);
                end else begin
                    o_upd.rsp.status = 1'b1;
                end
                for (int w = 0; w < WAYS; w++) begin
                    if (w_hit[w]) begin
                        o_upd.row[w].count = o_upd.rsp.count;
                    end else if (w_free[w] && !w_any_hit) begin
                        o_upd.row[w].valid = 1'b1;
                        o_upd.row[w].key   = i_key;
                        o_upd.row[w].count = COUNT_W'(1);
                    end
                end
            end
            default: begin
                o_upd.we = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/hash_occurrence_counter.sv
// Top level of the hash occurrence counter: control sequencer, set memory and result register.
//
// Counting hash map for decimal keys, held in one memory of BUCKETS rows, each row a set
// of WAYS entries. An insert or query request occupies the block from acceptance until
// the next request can be taken: the hash unit walks one digit per cycle, then the row
// is read, modified and written through the memory's single read port, the result is
// handed to the output register once the output is not stalled, and the block returns
// to idle. Unused action codes go straight to the result step. A clear request sweeps
// every row of the memory, one row per cycle; the same sweep runs after reset, and no
// request is accepted until it ends. A full set drops an insert and reports status 1;
// counts saturate.
`include "hash_occurrence_counter_macros.svh"
`timescale 1ns / 1ps
module hash_occurrence_counter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hoc_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hoc_pkg::t_out_rsp o_out_rsp
);
    import hoc_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [BUCKET_BITS-1:0] r_clr_addr;
    logic [BUCKET_BITS-1:0] n_clr_addr;
    logic                   r_clr_rsp;
    logic                   n_clr_rsp;
    t_in_req                r_req;
    t_out_rsp               r_rsp;
    t_out_rsp               n_rsp;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_out_rsp               r_out;

    logic                   w_accept;
    logic                   w_start;
    logic                   w_clr_last;
    logic                   w_out_load;
    logic                   w_we;
    logic [BUCKET_BITS-1:0] w_waddr;
    t_row                   w_wdata;
    t_row                   w_rdata;
    t_hash_res              w_hash;
    t_update                w_upd;

    hoc_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_key   (i_in_req.key),
        .o_res   (w_hash)
    );

    hoc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_hash.bucket),
        .o_rdata (w_rdata)
    );

    hoc_update u_update (
        .i_row    (w_rdata),
        .i_action (r_req.action),
        .i_key    (r_req.key),
        .o_upd    (w_upd)
    );

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_clr_last = (r_clr_addr == {BUCKET_BITS{1'b1}});

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = r_clr_rsp ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_req.action)
                        ACT_INSERT, ACT_QUERY: n_state = ST_HASH;
                        ACT_CLEAR:             n_state = ST_CLEAR;
                        default:               n_state = ST_RESP;
                    endcase
                end
            end
            ST_HASH: begin
                // The bucket is on the read address while done is high.
                if (w_hash.done) begin
                    n_state = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_stall = 1'b1;
        w_start    = 1'b0;
        w_out_load = 1'b0;
        w_we       = 1'b0;
        w_waddr    = w_hash.bucket;
        w_wdata    = w_upd.row;
        n_clr_addr = r_clr_addr;
        n_clr_rsp  = r_clr_rsp;
        n_rsp      = r_rsp;
        case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_start    = i_in_valid && ((i_in_req.action == ACT_INSERT)
                                            || (i_in_req.action == ACT_QUERY));
                n_clr_addr = '0;
                n_clr_rsp  = 1'b1;
                n_rsp      = '0;
            end
            ST_MODIFY: begin
                w_we  = w_upd.we;
                n_rsp = w_upd.rsp;
            end
            ST_RESP: begin
                w_out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_rsp   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_rsp   <= n_clr_rsp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (w_accept) begin
            r_req <= i_in_req;
        end
        if (w_out_load) begin
            r_out <= r_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    `HOC_ASSERT_SAME(a_no_write_idle, (r_state == ST_IDLE), !w_we, "memory written while idle")
    `HOC_ASSERT_SAME(a_query_no_write, (r_state == ST_MODIFY) && (r_req.action == ACT_QUERY), !w_we, "query wrote the memory")
    `HOC_ASSERT_SAME(a_drop_zero, o_out_valid && o_out_rsp.status, (o_out_rsp.count == '0), "dropped insert with nonzero count")
    `HOC_ASSERT_NEXT(a_busy_after_accept, w_accept, o_in_stall, "second request taken while one is in progress")

endmodule
